@@ rtl/core/pms_pkg.sv @@
package pms_pkg;

  // Default sizes
  localparam int NUM_STACKS_DEF  = 8;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  // Field widths
  localparam int OP_W     = 2;
  localparam int IDX_W    = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/pms_req_if.sv @@
interface pms_req_if;
  logic                       valid;
  logic                       ready;
  logic [pms_pkg::OP_W-1:0]   op;
  logic [pms_pkg::IDX_W-1:0]  stack_index;
  logic [pms_pkg::WORD_W-1:0] push_data;

  modport source (output valid, output op, output stack_index, output push_data,
                  input ready);
  modport sink (input valid, input op, input stack_index, input push_data,
                output ready);
endinterface

@@ rtl/core/pms_rsp_if.sv @@
interface pms_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pms_pkg::STATUS_W-1:0] status;
  logic [pms_pkg::WORD_W-1:0]   read_data;

  modport source (output valid, output status, output read_data, input ready);
  modport sink (input valid, input status, input read_data, output ready);
endinterface

@@ rtl/core/pms_fill_mem.sv @@
module pms_fill_mem #(
  parameter int NUM_STACKS = pms_pkg::NUM_STACKS_DEF,
  parameter int FILL_W     = 5,
  parameter int SIDX_W     = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              re,
  input  logic              we,
  input  logic [SIDX_W-1:0] addr,
  input  logic [FILL_W-1:0] wdata,
  output logic [FILL_W-1:0] rdata
);

  logic [FILL_W-1:0]     mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] vld;
  logic [FILL_W-1:0]     rd_q;
  logic                  vld_q;

  // valid bits stand in for the zero reset of the counts
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q  <= mem[addr];
      vld_q <= vld[addr];
    end
  end

  assign rdata = vld_q ? rd_q : '0;

endmodule

@@ rtl/core/pms_entry_mem.sv @@
module pms_entry_mem #(
  parameter int DEPTH      = 128,
  parameter int ADDR_W     = 7,
  parameter int DATA_WIDTH = pms_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  re,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/core/partitioned_multi_stack.sv @@
// Several LIFO stacks of STACK_DEPTH words share one entry memory; stack s owns
// the words from s*STACK_DEPTH up, and its fill count sits in a small count
// memory that reads as zero until the stack is first pushed. Each item (push,
// pop or peek on one stack) gives one result with a status and the top word.
// The block handles one item at a time: req.ready is high only while no item
// is in flight. A push or an error result goes from the count read (ST_FILL)
// to ST_DONE, a successful pop or peek via ST_READ (entry read); ST_DONE waits
// for a free output register, and the next item can be taken the cycle after
// the result is loaded into it, never before the last item is done.
module partitioned_multi_stack #(
  parameter int NUM_STACKS  = pms_pkg::NUM_STACKS_DEF,
  parameter int STACK_DEPTH = pms_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = pms_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pms_req_if.sink   req,
  pms_rsp_if.source rsp
);

  localparam int WORDS  = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);

  pms_pkg::state_t state, state_next;

  logic [pms_pkg::OP_W-1:0]     op_q;
  logic [pms_pkg::IDX_W-1:0]    idx_q;
  logic [DATA_WIDTH-1:0]        data_q;
  logic [pms_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [pms_pkg::WORD_W-1:0]   res_data, res_data_next;
  logic                         rsp_valid;
  logic [pms_pkg::STATUS_W-1:0] rsp_status;
  logic [pms_pkg::WORD_W-1:0]   rsp_data;

  logic                  fill_re, fill_we;
  logic [SIDX_W-1:0]     fill_addr;
  logic [FILL_W-1:0]     fill_cur, fill_wdata;
  logic                  ent_re, ent_we;
  logic [ADDR_W-1:0]     ent_addr, base;
  logic [DATA_WIDTH-1:0] ent_rdata;

  logic accept, out_free, in_range, full, empty, is_push, is_rd;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == pms_pkg::ST_IDLE);

  assign in_range = (int'(idx_q) < NUM_STACKS);
  assign full     = (fill_cur >= FILL_W'(STACK_DEPTH));
  assign empty    = (fill_cur == '0);
  assign is_push  = (op_q == pms_pkg::OP_PUSH);
  assign is_rd    = (op_q == pms_pkg::OP_POP) || (op_q == pms_pkg::OP_PEEK);
  assign base     = ADDR_W'(int'(idx_q) * STACK_DEPTH);

  pms_fill_mem #(
    .NUM_STACKS (NUM_STACKS),
    .FILL_W     (FILL_W),
    .SIDX_W     (SIDX_W)
  ) u_fill (
    .clk   (clk),
    .rst   (rst),
    .re    (fill_re),
    .we    (fill_we),
    .addr  (fill_addr),
    .wdata (fill_wdata),
    .rdata (fill_cur)
  );

  pms_entry_mem #(
    .DEPTH      (WORDS),
    .ADDR_W     (ADDR_W),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_entry (
    .clk   (clk),
    .re    (ent_re),
    .we    (ent_we),
    .addr  (ent_addr),
    .wdata (data_q),
    .rdata (ent_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pms_pkg::ST_IDLE: begin
        if (accept) state_next = pms_pkg::ST_FILL;
      end
      pms_pkg::ST_FILL: begin
        if (is_rd && in_range && !empty) state_next = pms_pkg::ST_READ;
        else state_next = pms_pkg::ST_DONE;
      end
      pms_pkg::ST_READ: state_next = pms_pkg::ST_DONE;
      pms_pkg::ST_DONE: begin
        if (out_free) state_next = pms_pkg::ST_IDLE;
      end
      default: state_next = pms_pkg::ST_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    fill_re         = 1'b0;
    fill_we         = 1'b0;
    fill_addr       = SIDX_W'(idx_q);
    fill_wdata      = fill_cur;
    ent_re          = 1'b0;
    ent_we          = 1'b0;
    ent_addr        = base + ADDR_W'(fill_cur);
    res_status_next = res_status;
    res_data_next   = res_data;
    unique case (state)
      pms_pkg::ST_IDLE: begin
        fill_re   = accept;
        fill_addr = SIDX_W'(req.stack_index);
      end
      pms_pkg::ST_FILL: begin
        res_status_next = pms_pkg::STAT_OK;
        res_data_next   = '0;
        if (is_push) begin
          if (!in_range || full) begin
            res_status_next = pms_pkg::STAT_FULL;
          end else begin
            ent_we     = 1'b1;
            fill_we    = 1'b1;
            fill_wdata = fill_cur + FILL_W'(1);
          end
        end else if (is_rd) begin
          if (!in_range || empty) begin
            res_status_next = pms_pkg::STAT_EMPTY;
          end else begin
            ent_re     = 1'b1;
            ent_addr   = base + ADDR_W'(fill_cur - FILL_W'(1));
            fill_we    = (op_q == pms_pkg::OP_POP);
            fill_wdata = fill_cur - FILL_W'(1);
          end
        end
      end
      pms_pkg::ST_READ: res_data_next = pms_pkg::WORD_W'(ent_rdata);
      pms_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req.op;
      idx_q  <= req.stack_index;
      data_q <= DATA_WIDTH'(req.push_data);
    end
    res_status <= res_status_next;
    res_data   <= res_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == pms_pkg::ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pms_pkg::ST_DONE && out_free) begin
      rsp_status <= res_status;
      rsp_data   <= res_data;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.read_data = rsp_data;

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ent_re && ent_we))
    else $error("entry memory read and write in the same cycle");

  a_accept_to_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == pms_pkg::ST_FILL)
    else $error("accepted item did not start a count read");

  a_read_to_data: assert property (@(posedge clk) disable iff (rst)
    ent_re |=> state == pms_pkg::ST_READ)
    else $error("entry read not followed by data capture");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == pms_pkg::ST_DONE))
    else $error("result appeared without a finished item");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACKS = pms_pkg::NUM_STACKS_DEF;
  localparam int DEPTH  = pms_pkg::STACK_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 20;

  // op code 3 is not decoded by the block
  localparam logic [pms_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // idling phases
  localparam int PH_FREE  = 0;
  localparam int PH_SEND  = 1;
  localparam int PH_RECV  = 2;
  localparam int PH_BOTH  = 3;

  typedef struct {
    logic [pms_pkg::OP_W-1:0]   op;
    logic [pms_pkg::IDX_W-1:0]  stack_index;
    logic [pms_pkg::WORD_W-1:0] push_data;
  } stack_cmd_t;

  typedef struct {
    logic [pms_pkg::STATUS_W-1:0] status;
    logic [pms_pkg::WORD_W-1:0]   read_data;
  } stack_result_t;

  logic clk;
  logic rst;

  pms_req_if req_ch ();
  pms_rsp_if rsp_ch ();

  partitioned_multi_stack dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow of the stacks
  int unsigned                fill_cnt [STACKS];
  logic [pms_pkg::WORD_W-1:0] word_mem [STACKS*DEPTH];

  stack_cmd_t    cmd_q[$];
  stack_result_t result_q[$];

  int unsigned n_sent;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned mismatch_cnt;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic stack_result_t apply_stack_op(stack_cmd_t cmd);
    stack_result_t r;
    int unsigned s;
    r.status = pms_pkg::STAT_OK;
    r.read_data = '0;
    s = cmd.stack_index;
    case (cmd.op)
      pms_pkg::OP_PUSH: begin
        if (s >= STACKS || fill_cnt[s] >= DEPTH) begin
          r.status = pms_pkg::STAT_FULL;
        end else begin
          word_mem[s*DEPTH + fill_cnt[s]] = cmd.push_data;
          fill_cnt[s]++;
        end
      end
      pms_pkg::OP_POP, pms_pkg::OP_PEEK: begin
        if (s >= STACKS || fill_cnt[s] == 0) begin
          r.status = pms_pkg::STAT_EMPTY;
        end else begin
          r.read_data = word_mem[s*DEPTH + fill_cnt[s] - 1];
          if (cmd.op == pms_pkg::OP_POP) fill_cnt[s]--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  // driver: one assignment per signal per falling edge
  always @(negedge clk) begin
    stack_cmd_t nxt;
    if (!rst && n_sent == n_accepted) begin
      if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = cmd_q.pop_front();
        req_ch.op          <= nxt.op;
        req_ch.stack_index <= nxt.stack_index;
        req_ch.push_data   <= nxt.push_data;
        req_ch.valid       <= 1'b1;
        n_sent++;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    stack_cmd_t    cmd;
    stack_result_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        cmd.op          = req_ch.op;
        cmd.stack_index = req_ch.stack_index;
        cmd.push_data   = req_ch.push_data;
        result_q.push_back(apply_stack_op(cmd));
        n_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (result_q.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected: status %0d data %08h",
                                  n_results, rsp_ch.status, rsp_ch.read_data));
        end else begin
          want = result_q.pop_front();
          if (rsp_ch.status !== want.status)
            note_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                    n_results, want.status, rsp_ch.status));
          if (rsp_ch.read_data !== want.read_data)
            note_mismatch($sformatf("result %0d read_data: expected %08h, got %08h",
                                    n_results, want.read_data, rsp_ch.read_data));
        end
        n_results++;
      end
    end
  end

  task automatic add_cmd(input logic [pms_pkg::OP_W-1:0] op,
                         input logic [pms_pkg::IDX_W-1:0] idx,
                         input logic [pms_pkg::WORD_W-1:0] data);
    stack_cmd_t cmd;
    cmd.op = op;
    cmd.stack_index = idx;
    cmd.push_data = data;
    cmd_q.push_back(cmd);
  endtask

  // bursts lean toward pushes or pops, often on one stack, so stacks fill and drain
  task automatic add_random_cmds(input int count);
    int push_pct;
    int focus;
    int roll;
    logic [pms_pkg::OP_W-1:0]   op;
    logic [pms_pkg::IDX_W-1:0]  idx;
    logic [pms_pkg::WORD_W-1:0] data;
    push_pct = 50;
    focus = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        push_pct = $urandom_range(1) ? 80 : 20;
        focus = $urandom_range(STACKS-1);
      end
      roll = $urandom_range(99);
      if (roll < 3) op = OP_UNUSED;
      else if (roll < push_pct) op = pms_pkg::OP_PUSH;
      else op = ($urandom_range(2) == 0) ? pms_pkg::OP_PEEK : pms_pkg::OP_POP;
      idx = $urandom_range(1) ? focus[pms_pkg::IDX_W-1:0]
                              : pms_pkg::IDX_W'($urandom_range(7));
      case ($urandom_range(9))
        0: data = '0;
        1: data = '1;
        default: data = $urandom;
      endcase
      add_cmd(op, idx, data);
      @(posedge clk);
    end
  endtask

  // wait until every queued command is sent and every outstanding result is back
  task automatic drain();
    while (cmd_q.size() != 0 || n_sent != n_accepted || result_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_phase(input int ph);
    case (ph)
      PH_SEND: begin send_idle_pct = 84; recv_stall_pct = 0;  end
      PH_RECV: begin send_idle_pct = 0;  recv_stall_pct = 84; end
      PH_BOTH: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  initial begin
    int phases [8];
    phases = '{PH_FREE, PH_SEND, PH_RECV, PH_BOTH, PH_BOTH, PH_RECV, PH_SEND, PH_FREE};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = pms_pkg::OP_PUSH;
    req_ch.stack_index = '0;
    req_ch.push_data = '0;
    rsp_ch.ready = 1'b0;
    n_sent = 0;
    n_accepted = 0;
    n_results = 0;
    mismatch_cnt = 0;
    set_phase(PH_FREE);
    foreach (fill_cnt[i]) fill_cnt[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // directed: word extremes, empty stacks, unused op, one stack to full
    add_cmd(pms_pkg::OP_PUSH, 3'd0, 32'h0000_0000);
    add_cmd(pms_pkg::OP_PUSH, 3'd7, 32'hFFFF_FFFF);
    add_cmd(pms_pkg::OP_PEEK, 3'd7, 32'h1234_5678);
    add_cmd(pms_pkg::OP_POP,  3'd7, 32'h0);
    add_cmd(pms_pkg::OP_POP,  3'd7, 32'h0);
    add_cmd(pms_pkg::OP_PEEK, 3'd3, 32'hFFFF_FFFF);
    add_cmd(OP_UNUSED, 3'd2, 32'hA5A5_5A5A);
    for (int k = 0; k < DEPTH; k++)
      add_cmd(pms_pkg::OP_PUSH, 3'd5, $urandom);
    add_cmd(pms_pkg::OP_PUSH, 3'd5, 32'hDEAD_BEEF);
    add_cmd(pms_pkg::OP_PEEK, 3'd5, 32'h0);
    drain();

    foreach (phases[p]) begin
      set_phase(phases[p]);
      add_random_cmds(225);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
